>>> rtl/bsm_pkg.sv
// Shared codes, widths, reset values and the result record of the bank switch mapper.
package bsm_pkg;

    localparam int OP_W     = 3;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int TGT_W    = 4;
    localparam int MADDR_W  = 21;
    localparam int MIRROR_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int WRAM_MASK_W = 13;
    localparam int PRESC_W  = 10;

    localparam int PRG_ADDR_BITS_DEF   = 21;
    localparam int CHR_ADDR_BITS_DEF   = 18;
    localparam int PRESCALE_PERIOD_DEF = 341;

    // bus event codes
    localparam logic [OP_W-1:0] OP_CPU_RD  = 3'd0;
    localparam logic [OP_W-1:0] OP_CPU_WR  = 3'd1;
    localparam logic [OP_W-1:0] OP_CPU_TICK = 3'd2;
    localparam logic [OP_W-1:0] OP_PPU_RD  = 3'd3;
    localparam logic [OP_W-1:0] OP_PPU_WR  = 3'd4;

    // access targets
    localparam logic [TGT_W-1:0] TGT_OPEN_BUS  = 4'd0;
    localparam logic [TGT_W-1:0] TGT_SYSRAM    = 4'd1;
    localparam logic [TGT_W-1:0] TGT_PPU_REGS  = 4'd2;
    localparam logic [TGT_W-1:0] TGT_APU_REGS  = 4'd3;
    localparam logic [TGT_W-1:0] TGT_WRAM      = 4'd4;
    localparam logic [TGT_W-1:0] TGT_PRG       = 4'd5;
    localparam logic [TGT_W-1:0] TGT_MAPPER    = 4'd6;
    localparam logic [TGT_W-1:0] TGT_CHR_ROM   = 4'd7;
    localparam logic [TGT_W-1:0] TGT_CHR_RAM   = 4'd8;
    localparam logic [TGT_W-1:0] TGT_NAMETABLE = 4'd9;
    localparam logic [TGT_W-1:0] TGT_NONE      = 4'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_MASK     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_MASK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAM_PRESENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAM_MASK    = 2'd3;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0]  PRG_MASK_RST  = 21'h1FE000;
    localparam logic [CFG_DATA_W-1:0]  CHR_MASK_RST  = 21'h03FC00;
    localparam logic [WRAM_MASK_W-1:0] WRAM_MASK_RST = 13'h1FFF;

    // mirroring modes
    localparam logic [MIRROR_W-1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [MIRROR_W-1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [MIRROR_W-1:0] MIR_SINGLE0    = 2'd2;
    localparam logic [MIRROR_W-1:0] MIR_SINGLE1    = 2'd3;

    typedef logic [MADDR_W-1:0] t_maddr;

    typedef struct packed {
        logic [TGT_W-1:0]    target;
        logic [MADDR_W-1:0]  mapped_addr;
        logic [DATA_W-1:0]   write_data;
        logic                irq;
        logic [MIRROR_W-1:0] mirror_mode;
    } t_result;

endpackage

>>> rtl/bank_switch_mapper_with_irq_core.sv
// Top level of the bank switch mapper: address translation, mapper registers and IRQ counter.
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  -------------------------------------
//  in        sink       i_in_valid / o_in_stall      i_op, i_addr, i_data
//  out       source     o_out_valid / i_out_stall    o_target, o_mapped_addr, o_write_data,
//                                                    o_irq, o_mirror_mode
//  cfg       sink       i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  For every bus event, decode, bank lookup and the IRQ counter update form a
//  single combinational pass from the input ports into the output register.
//  One transfer per clock is taken as long as the output side keeps up; a two-entry output
//  (main register plus skid register) lets one more transfer in while a result is stalled.
//  o_in_stall rises only when both output entries are full.
//  Reset (i_rst_n low, synchronous) clears bank registers, IRQ state and the output queue,
//  and loads the configuration registers with their defaults.
module bank_switch_mapper_with_irq_core
    import bsm_pkg::*;
#(
    parameter int PRG_ADDR_BITS   = PRG_ADDR_BITS_DEF,
    parameter int CHR_ADDR_BITS   = CHR_ADDR_BITS_DEF,
    parameter int PRESCALE_PERIOD = PRESCALE_PERIOD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_op,
    input  logic [ADDR_W-1:0]     i_addr,
    input  logic [DATA_W-1:0]     i_data,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TGT_W-1:0]      o_target,
    output logic [MADDR_W-1:0]    o_mapped_addr,
    output logic [DATA_W-1:0]     o_write_data,
    output logic                  o_irq,
    output logic [MIRROR_W-1:0]   o_mirror_mode,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [PRESC_W-1:0] PRESCALE_INIT = PRESC_W'(PRESCALE_PERIOD);
    localparam logic [PRESC_W-1:0] PRESCALE_STEP = 10'd3;

    // CPU address regions on A15-A13
    localparam logic [2:0] REG_SYSRAM = 3'd0;
    localparam logic [2:0] REG_PPU    = 3'd1;
    localparam logic [2:0] REG_APU    = 3'd2;
    localparam logic [2:0] REG_WRAM   = 3'd3;

    // PRG windows on A14-A13 inside 0x8000-0xFFFF
    localparam logic [1:0] WIN_PRG0  = 2'd0;
    localparam logic [1:0] WIN_PRG1  = 2'd1;
    localparam logic [1:0] WIN_PRG2  = 2'd2;
    localparam logic [1:0] WIN_FIXED = 2'd3;

    // mapper register groups on A15-A12
    localparam logic [3:0] GRP_PRG01 = 4'h8;
    localparam logic [3:0] GRP_PRG2  = 4'h9;
    localparam logic [3:0] GRP_CHR01 = 4'hA;
    localparam logic [3:0] GRP_CHR23 = 4'hB;
    localparam logic [3:0] GRP_CHR45 = 4'hC;
    localparam logic [3:0] GRP_CHR67 = 4'hD;
    localparam logic [3:0] GRP_IRQLD = 4'hE;

    // configuration registers
    logic [PRG_ADDR_BITS-1:0] r_prg_mask;
    logic [CHR_ADDR_BITS-1:0] r_chr_mask;
    logic                     r_wram_present;
    logic [WRAM_MASK_W-1:0]   r_wram_mask;

    // mapper state and its next value
    logic [7:0]          r_prg_bank [3];
    logic [7:0]          n_prg_bank [3];
    logic [7:0]          r_chr_bank [8];
    logic [7:0]          n_chr_bank [8];
    logic [MIRROR_W-1:0] r_mirroring, n_mirroring;
    logic [7:0]          r_irq_reload, n_irq_reload;
    logic [7:0]          r_irq_count, n_irq_count;
    logic [PRESC_W-1:0]  r_prescaler, n_prescaler;
    logic                r_irq_pending, n_irq_pending;
    logic                r_irq_on, n_irq_on;
    logic                r_irq_on_after_ack, n_irq_on_after_ack;
    logic                r_irq_cycle_mode, n_irq_cycle_mode;

    // output queue
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    t_result res;

    logic in_fire;
    logic out_take;

    // decode helpers
    logic [3:0]               grp;
    logic                     second;
    logic [13:0]              pa;
    logic [7:0]               prg_sel;
    logic [PRG_ADDR_BITS-1:0] prg_off;
    logic [7:0]               chr_sel;
    logic [CHR_ADDR_BITS-1:0] chr_off;
    logic                     count_clk;

    assign in_fire    = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    assign grp    = i_addr[15:12];
    assign second = |i_addr[4:3];
    assign pa     = i_addr[13:0];

    // bank selection for the CPU PRG windows; the top window is fixed to the last bank
    always_comb begin
        case (i_addr[14:13])
            WIN_PRG0: prg_sel = r_prg_bank[0];
            WIN_PRG1: prg_sel = r_prg_bank[1];
            default:  prg_sel = r_prg_bank[2];
        endcase
        prg_off = (PRG_ADDR_BITS'({prg_sel, 13'b0}) & r_prg_mask)
                | PRG_ADDR_BITS'(i_addr[12:0]);
        chr_sel = r_chr_bank[pa[12:10]];
        chr_off = (CHR_ADDR_BITS'({chr_sel, 10'b0}) & r_chr_mask)
                | CHR_ADDR_BITS'(pa[9:0]);
    end

    // one pass per event: state update and result
    always_comb begin
        n_prg_bank         = r_prg_bank;
        n_chr_bank         = r_chr_bank;
        n_mirroring        = r_mirroring;
        n_irq_reload       = r_irq_reload;
        n_irq_count        = r_irq_count;
        n_prescaler        = r_prescaler;
        n_irq_pending      = r_irq_pending;
        n_irq_on           = r_irq_on;
        n_irq_on_after_ack = r_irq_on_after_ack;
        n_irq_cycle_mode   = r_irq_cycle_mode;
        count_clk          = 1'b0;

        res.target      = TGT_NONE;
        res.mapped_addr = '0;
        res.write_data  = '0;

        case (i_op)
            OP_CPU_RD, OP_CPU_WR: begin
                if (i_op == OP_CPU_WR) begin
                    res.write_data = i_data;
                end
                case (i_addr[15:13])
                    REG_SYSRAM: begin
                        res.target      = TGT_SYSRAM;
                        res.mapped_addr = t_maddr'(i_addr[10:0]);
                    end
                    REG_PPU: begin
                        res.target      = TGT_PPU_REGS;
                        res.mapped_addr = t_maddr'(i_addr[2:0]);
                    end
                    REG_APU: begin
                        res.target      = TGT_APU_REGS;
                        res.mapped_addr = t_maddr'(i_addr[12:0]);
                    end
                    REG_WRAM: begin
                        if (r_wram_present) begin
                            res.target      = TGT_WRAM;
                            res.mapped_addr = t_maddr'(i_addr[12:0] & r_wram_mask);
                        end else begin
                            // no work RAM: reads float, writes go nowhere
                            res.target = (i_op == OP_CPU_RD) ? TGT_OPEN_BUS : TGT_NONE;
                        end
                    end
                    default: begin
                        if (i_op == OP_CPU_WR) begin
                            res.target      = TGT_MAPPER;
                            res.mapped_addr = t_maddr'(i_addr);
                            case (grp)
                                GRP_PRG01: n_prg_bank[{1'b0, second}] = i_data;
                                GRP_PRG2: begin
                                    // second half of this group is the audio port: drop
                                    if (!second) begin
                                        n_prg_bank[2] = i_data;
                                    end
                                end
                                GRP_CHR01: n_chr_bank[{2'b00, second}] = i_data;
                                GRP_CHR23: n_chr_bank[{2'b01, second}] = i_data;
                                GRP_CHR45: n_chr_bank[{2'b10, second}] = i_data;
                                GRP_CHR67: n_chr_bank[{2'b11, second}] = i_data;
                                GRP_IRQLD: begin
                                    if (second) begin
                                        n_irq_reload = i_data;
                                    end else begin
                                        n_mirroring = i_data[1:0];
                                    end
                                end
                                default: begin
                                    if (second) begin
                                        // acknowledge
                                        n_irq_pending = 1'b0;
                                        n_irq_on      = r_irq_on_after_ack;
                                    end else begin
                                        n_irq_on_after_ack = i_data[0];
                                        n_irq_on           = i_data[1];
                                        n_irq_cycle_mode   = i_data[2];
                                        if (i_data[1]) begin
                                            n_irq_count = r_irq_reload;
                                            n_prescaler = PRESCALE_INIT;
                                        end
                                        n_irq_pending = 1'b0;
                                    end
                                end
                            endcase
                        end else begin
                            res.target = TGT_PRG;
                            if (i_addr[14:13] == WIN_FIXED) begin
                                res.mapped_addr = t_maddr'(PRG_ADDR_BITS'(i_addr[12:0])
                                                           | r_prg_mask);
                            end else begin
                                res.mapped_addr = t_maddr'(prg_off);
                            end
                        end
                    end
                endcase
            end
            OP_CPU_TICK: begin
                if (r_irq_on) begin
                    if (r_irq_cycle_mode) begin
                        count_clk = 1'b1;
                    end else if (r_prescaler <= PRESCALE_STEP) begin
                        n_prescaler = r_prescaler + PRESCALE_INIT - PRESCALE_STEP;
                        count_clk   = 1'b1;
                    end else begin
                        n_prescaler = r_prescaler - PRESCALE_STEP;
                    end
                end
                if (count_clk) begin
                    if (r_irq_count == 8'hFF) begin
                        n_irq_pending = 1'b1;
                        n_irq_count   = r_irq_reload;
                    end else begin
                        n_irq_count = r_irq_count + 8'd1;
                    end
                end
            end
            OP_PPU_RD, OP_PPU_WR: begin
                if (i_op == OP_PPU_WR) begin
                    res.write_data = i_data;
                end
                if (!pa[13]) begin
                    if (i_op == OP_PPU_WR) begin
                        // pattern writes bypass banking
                        res.target      = TGT_CHR_RAM;
                        res.mapped_addr = t_maddr'(pa[12:0]);
                    end else begin
                        res.target      = TGT_CHR_ROM;
                        res.mapped_addr = t_maddr'(chr_off);
                    end
                end else begin
                    // nametable and palette area, folded into 2K of CIRAM
                    res.target = TGT_NAMETABLE;
                    case (r_mirroring)
                        MIR_VERTICAL:   res.mapped_addr = t_maddr'(pa[10:0]);
                        MIR_HORIZONTAL: res.mapped_addr = t_maddr'({pa[11], pa[9:0]});
                        MIR_SINGLE0:    res.mapped_addr = t_maddr'({1'b0, pa[9:0]});
                        default:        res.mapped_addr = t_maddr'({1'b1, pa[9:0]});
                    endcase
                end
            end
            default: begin
                res.target = TGT_NONE;
            end
        endcase

        // IRQ line and mirroring as they stand after this event
        res.irq         = n_irq_pending;
        res.mirror_mode = n_mirroring;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask     <= PRG_MASK_RST[PRG_ADDR_BITS-1:0];
            r_chr_mask     <= CHR_MASK_RST[CHR_ADDR_BITS-1:0];
            r_wram_present <= 1'b1;
            r_wram_mask    <= WRAM_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRG_MASK:     r_prg_mask     <= i_cfg_data[PRG_ADDR_BITS-1:0];
                CFG_CHR_MASK:     r_chr_mask     <= i_cfg_data[CHR_ADDR_BITS-1:0];
                CFG_WRAM_PRESENT: r_wram_present <= i_cfg_data[0];
                CFG_WRAM_MASK:    r_wram_mask    <= i_cfg_data[WRAM_MASK_W-1:0];
                default:          r_wram_mask    <= r_wram_mask;
            endcase
        end
    end

    // advance mapper state on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank         <= '{default: '0};
            r_chr_bank         <= '{default: '0};
            r_mirroring        <= MIR_VERTICAL;
            r_irq_reload       <= '0;
            r_irq_count        <= '0;
            r_prescaler        <= PRESCALE_INIT;
            r_irq_pending      <= 1'b0;
            r_irq_on           <= 1'b0;
            r_irq_on_after_ack <= 1'b0;
            r_irq_cycle_mode   <= 1'b0;
        end else if (in_fire) begin
            r_prg_bank         <= n_prg_bank;
            r_chr_bank         <= n_chr_bank;
            r_mirroring        <= n_mirroring;
            r_irq_reload       <= n_irq_reload;
            r_irq_count        <= n_irq_count;
            r_prescaler        <= n_prescaler;
            r_irq_pending      <= n_irq_pending;
            r_irq_on           <= n_irq_on;
            r_irq_on_after_ack <= n_irq_on_after_ack;
            r_irq_cycle_mode   <= n_irq_cycle_mode;
        end
    end

    // output register with skid: hold while stalled, park one extra result in the skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            r_out_valid  <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_fire) begin
            r_skid <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_target      = r_out.target;
    assign o_mapped_addr = r_out.mapped_addr;
    assign o_write_data  = r_out.write_data;
    assign o_irq         = r_out.irq;
    assign o_mirror_mode = r_out.mirror_mode;

endmodule

>>> rtl/bsm_checker.sv
// Port-level checks for the bank switch mapper, bound to its top level.
module bsm_checker
    import bsm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic [OP_W-1:0]     i_op,
    input logic [ADDR_W-1:0]   i_addr,
    input logic [DATA_W-1:0]   i_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [TGT_W-1:0]    o_target,
    input logic [MADDR_W-1:0]  o_mapped_addr,
    input logic [DATA_W-1:0]   o_write_data,
    input logic                o_irq,
    input logic [MIRROR_W-1:0] o_mirror_mode
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // an event taken with the output empty shows up on the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !o_out_valid |=> o_out_valid)
        else $error("accepted event did not reach the output in one cycle");

    // a mirroring write is reflected in its own result
    a_mirror_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !o_out_valid && i_op == OP_CPU_WR && i_addr[15:12] == 4'hE
            && i_addr[4:3] == 2'b00
        |=> o_target == TGT_MAPPER && o_mirror_mode == $past(i_data[1:0]))
        else $error("mirroring write not reflected in result");

    // an acknowledge drops the IRQ line in its own result
    a_irq_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !o_out_valid && i_op == OP_CPU_WR && i_addr[15:12] == 4'hF
            && i_addr[4:3] != 2'b00
        |=> !o_irq)
        else $error("IRQ still high after acknowledge");

    // pattern writes go unbanked to CHR RAM with their data
    a_chr_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !o_out_valid && i_op == OP_PPU_WR && !i_addr[13]
        |=> o_target == TGT_CHR_RAM && o_mapped_addr == t_maddr'($past(i_addr[12:0]))
            && o_write_data == $past(i_data))
        else $error("CHR RAM write translated wrongly");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall
        |=> o_out_valid && $stable(o_target) && $stable(o_mapped_addr)
            && $stable(o_write_data) && $stable(o_irq) && $stable(o_mirror_mode))
        else $error("stalled result changed");

endmodule

bind bank_switch_mapper_with_irq_core bsm_checker u_bsm_checker (.*);
